// File: hw/rtl/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical timer wheel package
// Shared constants, operation and status codes, sequencer states and
// memory write-enable groups.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int LEVEL0_BITS_DEF      = 8;
  localparam int UPPER_LEVEL_BITS_DEF = 6;
  localparam int POOL_SIZE_DEF        = 64;

  localparam int NUM_UPPER = 4;
  localparam int ID_W      = 6;
  localparam int DELAY_W   = 32;
  localparam int TICK_W    = 64;

  localparam logic [2:0] LVL_FIRST = 3'd1;
  localparam logic [2:0] LVL_TOP   = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_REMOVED    = 3'd1,
    ST_EXPIRED    = 3'd2,
    ST_NONE       = 3'd3,
    ST_BUSY       = 3'd4,
    ST_NOT_ACTIVE = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN_RD,
    S_DRAIN_HEAD,
    S_DRAIN_WALK,
    S_DRAIN_NEXT,
    S_ADV,
    S_CAS_RD,
    S_CAS_HEAD,
    S_CAS_WALK,
    S_CAS_ENT,
    S_FILE_RD,
    S_FILE_WR,
    S_FILE_LINK,
    S_RM_ENT,
    S_RM_TAIL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic nxt;
    logic prv;
    logic dl;
    logic bkt;
  } entry_we_t;

  typedef struct packed {
    logic head;
    logic tail;
  } bucket_we_t;

endpackage

// File: hw/rtl/htw_bucket_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket list memory
// Head and tail pointer of every bucket, separate write enables, one
// registered read port.
// ----------------------------------------------------------------------------
module htw_bucket_ram
  import htw_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int PW    = 7
) (
  input  logic          clk_i,
  input  logic [AW-1:0] raddr_i,
  input  logic [AW-1:0] waddr_i,
  input  bucket_we_t    we_i,
  input  logic [PW-1:0] whead_i,
  input  logic [PW-1:0] wtail_i,
  output logic [PW-1:0] rhead_o,
  output logic [PW-1:0] rtail_o
);

  logic [PW-1:0] head_mem [DEPTH];
  logic [PW-1:0] tail_mem [DEPTH];
  logic [PW-1:0] rhead_q;
  logic [PW-1:0] rtail_q;

  always_ff @(posedge clk_i) begin
    if (we_i.head) begin
      head_mem[waddr_i] <= whead_i;
    end
    if (we_i.tail) begin
      tail_mem[waddr_i] <= wtail_i;
    end
    rhead_q <= head_mem[raddr_i];
    rtail_q <= tail_mem[raddr_i];
  end

  assign rhead_o = rhead_q;
  assign rtail_o = rtail_q;

endmodule

// File: hw/rtl/htw_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer entry memory
// Link pointers, deadline and owning bucket of every pool entry, with
// per-field write enables and one registered read port.
// ----------------------------------------------------------------------------
module htw_entry_ram
  import htw_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int PW    = 7,
  parameter int BW    = 9
) (
  input  logic              clk_i,
  input  logic [IW-1:0]     raddr_i,
  input  logic [IW-1:0]     waddr_i,
  input  entry_we_t         we_i,
  input  logic [PW-1:0]     wnext_i,
  input  logic [PW-1:0]     wprev_i,
  input  logic [TICK_W-1:0] wdl_i,
  input  logic [BW-1:0]     wbkt_i,
  output logic [PW-1:0]     rnext_o,
  output logic [PW-1:0]     rprev_o,
  output logic [TICK_W-1:0] rdl_o,
  output logic [BW-1:0]     rbkt_o
);

  logic [PW-1:0]     next_mem [DEPTH];
  logic [PW-1:0]     prev_mem [DEPTH];
  logic [TICK_W-1:0] dl_mem   [DEPTH];
  logic [BW-1:0]     bkt_mem  [DEPTH];
  logic [PW-1:0]     rnext_q;
  logic [PW-1:0]     rprev_q;
  logic [TICK_W-1:0] rdl_q;
  logic [BW-1:0]     rbkt_q;

  always_ff @(posedge clk_i) begin
    if (we_i.nxt) begin
      next_mem[waddr_i] <= wnext_i;
    end
    if (we_i.prv) begin
      prev_mem[waddr_i] <= wprev_i;
    end
    if (we_i.dl) begin
      dl_mem[waddr_i] <= wdl_i;
    end
    if (we_i.bkt) begin
      bkt_mem[waddr_i] <= wbkt_i;
    end
    rnext_q <= next_mem[raddr_i];
    rprev_q <= prev_mem[raddr_i];
    rdl_q   <= dl_mem[raddr_i];
    rbkt_q  <= bkt_mem[raddr_i];
  end

  assign rnext_o = rnext_q;
  assign rprev_o = rprev_q;
  assign rdl_o   = rdl_q;
  assign rbkt_o  = rbkt_q;

endmodule

// File: hw/rtl/htw_filer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket selection
// Picks the level and bucket for a timer from its remaining ticks and the
// current wheel positions.
// ----------------------------------------------------------------------------
module htw_filer
  import htw_pkg::*;
#(
  parameter int LEVEL0_BITS      = LEVEL0_BITS_DEF,
  parameter int UPPER_LEVEL_BITS = UPPER_LEVEL_BITS_DEF,
  parameter int BW               = 9
) (
  input  logic [TICK_W-1:0]                          ival_i,
  input  logic [LEVEL0_BITS-1:0]                     pos0_i,
  input  logic [NUM_UPPER-1:0][UPPER_LEVEL_BITS-1:0] posu_i,
  output logic [BW-1:0]                              bkt_o
);

  localparam int L0_SIZE = 1 << LEVEL0_BITS;
  localparam int UP_SIZE = 1 << UPPER_LEVEL_BITS;

  always_comb begin
    logic [UPPER_LEVEL_BITS-1:0] slot;
    logic [BW-1:0]               cand [NUM_UPPER];
    int                          sel;
    sel = NUM_UPPER - 1;
    for (int k = 0; k < NUM_UPPER; k++) begin
      // (interval - T + pos*T) >> log2 T reduces to (interval >> log2 T) + pos - 1
      slot = UPPER_LEVEL_BITS'(ival_i >> (LEVEL0_BITS + k * UPPER_LEVEL_BITS))
             + posu_i[k] - UPPER_LEVEL_BITS'(1);
      cand[k] = BW'(L0_SIZE + k * UP_SIZE) + BW'(slot);
    end
    for (int k = NUM_UPPER - 2; k >= 0; k--) begin
      if ((ival_i >> (LEVEL0_BITS + (k + 1) * UPPER_LEVEL_BITS)) == '0) begin
        sel = k;
      end
    end
    if ((ival_i >> LEVEL0_BITS) == '0) begin
      bkt_o = BW'(LEVEL0_BITS'(ival_i[LEVEL0_BITS-1:0] + pos0_i));
    end else begin
      bkt_o = cand[sel[1:0]];
    end
  end

endmodule

// File: hw/rtl/hierarchical_timer_wheel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical timer wheel core
// Five-level timing wheel over a fixed pool of timers, kept as linked
// bucket lists in two synchronous memories and walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------
//  command  | start_i, operation_i, timer_id_i, delay_ticks_i | start_i & !busy_o
//  result   | valid_o, status_o, expired_id_o, last_o      | valid_o, one cycle
//
// A tick drains the current level-0 bucket and, on a wrap, cascades the
// current bucket of the next level up, expiring the due timers and re-filing
// the rest; every list step waits on a memory read.
// After reset the bucket memory is cleared, one bucket per cycle, over all
// 2^LEVEL0_BITS + 4 * 2^UPPER_LEVEL_BITS buckets with busy_o high.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_core
  import htw_pkg::*;
#(
  parameter int LEVEL0_BITS      = LEVEL0_BITS_DEF,
  parameter int UPPER_LEVEL_BITS = UPPER_LEVEL_BITS_DEF,
  parameter int POOL_SIZE        = POOL_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic [ID_W-1:0]    timer_id_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  output logic               valid_o,
  output logic [2:0]         status_o,
  output logic [ID_W-1:0]    expired_id_o,
  output logic               last_o
);

  localparam int L0_SIZE = 1 << LEVEL0_BITS;
  localparam int UP_SIZE = 1 << UPPER_LEVEL_BITS;
  localparam int NB      = L0_SIZE + NUM_UPPER * UP_SIZE;
  localparam int BW      = $clog2(NB);
  localparam int PW      = $clog2(POOL_SIZE + 1);
  localparam int IW      = $clog2(POOL_SIZE);
  localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);

  state_e state_q, state_d;

  logic [BW-1:0]                          clr_q, clr_d;
  logic [TICK_W-1:0]                      tick_q, tick_d;
  logic [LEVEL0_BITS-1:0]                 pos0_q, pos0_d;
  logic [NUM_UPPER-1:0][UPPER_LEVEL_BITS-1:0] posu_q, posu_d;
  logic [2:0]                             lvl_q, lvl_d;
  logic                                   wrap_q, wrap_d;
  logic [PW-1:0]                          cur_q, cur_d;
  logic [PW-1:0]                          nx_q, nx_d;
  logic [PW-1:0]                          tl_q, tl_d;
  logic [PW-1:0]                          pp_q, pp_d;
  logic [BW-1:0]                          bkt_q, bkt_d;
  logic [TICK_W-1:0]                      ival_q, ival_d;
  logic                                   is_add_q, is_add_d;
  logic [POOL_SIZE-1:0]                   active_q, active_d;
  logic                                   pend_v_q, pend_v_d;
  logic [PW-1:0]                          pend_q, pend_d;
  logic                                   vld_q, vld_d;
  status_e                                st_q, st_d;
  logic [ID_W-1:0]                        oid_q, oid_d;
  logic                                   last_q, last_d;

  // memory ports
  logic [BW-1:0]     bkt_raddr, bkt_waddr;
  bucket_we_t        bkt_we;
  logic [PW-1:0]     bkt_whead, bkt_wtail, bkt_rhead, bkt_rtail;
  logic [IW-1:0]     ent_raddr, ent_waddr;
  entry_we_t         ent_we;
  logic [PW-1:0]     ent_wnext, ent_wprev, ent_rnext, ent_rprev;
  logic [TICK_W-1:0] ent_wdl, ent_rdl;
  logic [BW-1:0]     ent_wbkt, ent_rbkt;
  logic [BW-1:0]     fil_bkt;

  op_e           op;
  logic          id_oob;
  logic [IW-1:0] id_idx;
  logic          id_act;
  logic          due;
  logic [1:0]    lidx;
  logic [BW-1:0] cas_bkt;

  assign op      = op_e'(operation_i);
  assign id_oob  = 32'(timer_id_i) >= POOL_SIZE;
  assign id_idx  = IW'(timer_id_i);
  assign id_act  = active_q[id_idx];
  assign due     = ent_rdl <= tick_q;
  assign lidx    = 2'(lvl_q - LVL_FIRST);
  assign cas_bkt = BW'(L0_SIZE) + (BW'(lidx) << UPPER_LEVEL_BITS) + BW'(posu_q[lidx]);

  htw_bucket_ram #(
    .DEPTH (NB),
    .AW    (BW),
    .PW    (PW)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .raddr_i (bkt_raddr),
    .waddr_i (bkt_waddr),
    .we_i    (bkt_we),
    .whead_i (bkt_whead),
    .wtail_i (bkt_wtail),
    .rhead_o (bkt_rhead),
    .rtail_o (bkt_rtail)
  );

  htw_entry_ram #(
    .DEPTH (POOL_SIZE),
    .IW    (IW),
    .PW    (PW),
    .BW    (BW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .raddr_i (ent_raddr),
    .waddr_i (ent_waddr),
    .we_i    (ent_we),
    .wnext_i (ent_wnext),
    .wprev_i (ent_wprev),
    .wdl_i   (ent_wdl),
    .wbkt_i  (ent_wbkt),
    .rnext_o (ent_rnext),
    .rprev_o (ent_rprev),
    .rdl_o   (ent_rdl),
    .rbkt_o  (ent_rbkt)
  );

  htw_filer #(
    .LEVEL0_BITS      (LEVEL0_BITS),
    .UPPER_LEVEL_BITS (UPPER_LEVEL_BITS),
    .BW               (BW)
  ) u_filer (
    .ival_i (ival_q),
    .pos0_i (pos0_q),
    .posu_i (posu_q),
    .bkt_o  (fil_bkt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == BW'(NB - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          case (op)
            OP_TICK:   state_d = S_DRAIN_RD;
            OP_ADD:    if (!id_oob && !id_act) state_d = S_FILE_RD;
            OP_REMOVE: if (!id_oob && id_act) state_d = S_RM_ENT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_DRAIN_RD:   state_d = S_DRAIN_HEAD;
      S_DRAIN_HEAD: state_d = S_DRAIN_WALK;
      S_DRAIN_WALK: state_d = (cur_q == NIL) ? S_ADV : S_DRAIN_NEXT;
      S_DRAIN_NEXT: state_d = S_DRAIN_WALK;
      S_ADV:        state_d = (pos0_q == '1) ? S_CAS_RD : S_FINISH;
      S_CAS_RD:     state_d = S_CAS_HEAD;
      S_CAS_HEAD:   state_d = S_CAS_WALK;
      S_CAS_WALK: begin
        if (cur_q != NIL) begin
          state_d = S_CAS_ENT;
        end else if (wrap_q && lvl_q != LVL_TOP) begin
          state_d = S_CAS_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_CAS_ENT:    state_d = due ? S_CAS_WALK : S_FILE_RD;
      S_FILE_RD:    state_d = S_FILE_WR;
      S_FILE_WR: begin
        if (bkt_rtail != NIL) begin
          state_d = S_FILE_LINK;
        end else begin
          state_d = is_add_q ? S_IDLE : S_CAS_WALK;
        end
      end
      S_FILE_LINK:  state_d = is_add_q ? S_IDLE : S_CAS_WALK;
      S_RM_ENT:     state_d = S_RM_TAIL;
      S_RM_TAIL:    state_d = S_IDLE;
      S_FINISH:     state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d    = clr_q;
    tick_d   = tick_q;
    pos0_d   = pos0_q;
    posu_d   = posu_q;
    lvl_d    = lvl_q;
    wrap_d   = wrap_q;
    cur_d    = cur_q;
    nx_d     = nx_q;
    tl_d     = tl_q;
    pp_d     = pp_q;
    bkt_d    = bkt_q;
    ival_d   = ival_q;
    is_add_d = is_add_q;
    active_d = active_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    vld_d    = 1'b0;
    st_d     = st_q;
    oid_d    = oid_q;
    last_d   = last_q;

    bkt_raddr = bkt_q;
    bkt_waddr = bkt_q;
    bkt_we    = '0;
    bkt_whead = NIL;
    bkt_wtail = NIL;
    ent_raddr = cur_q[IW-1:0];
    ent_waddr = cur_q[IW-1:0];
    ent_we    = '0;
    ent_wnext = NIL;
    ent_wprev = NIL;
    ent_wdl   = tick_q + TICK_W'(delay_ticks_i);
    ent_wbkt  = bkt_q;

    case (state_q)
      S_CLEAR: begin
        bkt_waddr = clr_q;
        bkt_we    = '{head: 1'b1, tail: 1'b1};
        clr_d     = clr_q + BW'(1);
      end
      S_IDLE: begin
        cur_d = PW'(timer_id_i);
        if (start_i) begin
          case (op)
            OP_ADD: begin
              if (id_oob || id_act) begin
                vld_d  = 1'b1;
                st_d   = id_oob ? ST_NOT_ACTIVE : ST_BUSY;
                oid_d  = timer_id_i;
                last_d = 1'b1;
              end else begin
                ent_waddr        = id_idx;
                ent_we.dl        = 1'b1;
                active_d[id_idx] = 1'b1;
                ival_d           = TICK_W'(delay_ticks_i);
                is_add_d         = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (id_oob || !id_act) begin
                vld_d  = 1'b1;
                st_d   = ST_NOT_ACTIVE;
                oid_d  = timer_id_i;
                last_d = 1'b1;
              end else begin
                ent_raddr        = id_idx;
                active_d[id_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAIN_RD: begin
        bkt_raddr = BW'(pos0_q);
      end
      S_DRAIN_HEAD: begin
        cur_d     = bkt_rhead;
        bkt_waddr = BW'(pos0_q);
        bkt_we    = '{head: 1'b1, tail: 1'b1};
      end
      S_DRAIN_WALK: begin
        if (cur_q != NIL) begin
          active_d[cur_q[IW-1:0]] = 1'b0;
          // hold the newest expiry back until it is known whether it is the last
          if (pend_v_q) begin
            vld_d  = 1'b1;
            st_d   = ST_EXPIRED;
            oid_d  = ID_W'(pend_q);
            last_d = 1'b0;
          end
          pend_d   = cur_q;
          pend_v_d = 1'b1;
        end
      end
      S_DRAIN_NEXT: begin
        cur_d = ent_rnext;
      end
      S_ADV: begin
        tick_d = tick_q + TICK_W'(1);
        pos0_d = pos0_q + LEVEL0_BITS'(1);
        lvl_d  = LVL_FIRST;
      end
      S_CAS_RD: begin
        bkt_raddr    = cas_bkt;
        bkt_d        = cas_bkt;
        posu_d[lidx] = posu_q[lidx] + UPPER_LEVEL_BITS'(1);
        wrap_d       = posu_q[lidx] == '1;
      end
      S_CAS_HEAD: begin
        cur_d  = bkt_rhead;
        bkt_we = '{head: 1'b1, tail: 1'b1};
      end
      S_CAS_WALK: begin
        if (cur_q == NIL && wrap_q && lvl_q != LVL_TOP) begin
          lvl_d = lvl_q + 3'd1;
        end
      end
      S_CAS_ENT: begin
        nx_d = ent_rnext;
        if (due) begin
          active_d[cur_q[IW-1:0]] = 1'b0;
          if (pend_v_q) begin
            vld_d  = 1'b1;
            st_d   = ST_EXPIRED;
            oid_d  = ID_W'(pend_q);
            last_d = 1'b0;
          end
          pend_d   = cur_q;
          pend_v_d = 1'b1;
          cur_d    = ent_rnext;
        end else begin
          ival_d   = ent_rdl - tick_q;
          is_add_d = 1'b0;
        end
      end
      S_FILE_RD: begin
        bkt_raddr = fil_bkt;
        bkt_d     = fil_bkt;
      end
      S_FILE_WR: begin
        tl_d      = bkt_rtail;
        ent_we    = '{nxt: 1'b1, prv: 1'b1, dl: 1'b0, bkt: 1'b1};
        ent_wnext = NIL;
        ent_wprev = bkt_rtail;
        ent_wbkt  = bkt_q;
        bkt_wtail = cur_q;
        bkt_whead = cur_q;
        bkt_we    = '{head: (bkt_rtail == NIL), tail: 1'b1};
        if (bkt_rtail == NIL) begin
          if (is_add_q) begin
            vld_d  = 1'b1;
            st_d   = ST_ADDED;
            oid_d  = ID_W'(cur_q);
            last_d = 1'b1;
          end else begin
            cur_d = nx_q;
          end
        end
      end
      S_FILE_LINK: begin
        ent_waddr = tl_q[IW-1:0];
        ent_we    = '{nxt: 1'b1, prv: 1'b0, dl: 1'b0, bkt: 1'b0};
        ent_wnext = cur_q;
        if (is_add_q) begin
          vld_d  = 1'b1;
          st_d   = ST_ADDED;
          oid_d  = ID_W'(cur_q);
          last_d = 1'b1;
        end else begin
          cur_d = nx_q;
        end
      end
      S_RM_ENT: begin
        pp_d  = ent_rprev;
        nx_d  = ent_rnext;
        bkt_d = ent_rbkt;
        if (ent_rprev != NIL) begin
          ent_waddr = ent_rprev[IW-1:0];
          ent_we    = '{nxt: 1'b1, prv: 1'b0, dl: 1'b0, bkt: 1'b0};
          ent_wnext = ent_rnext;
        end else begin
          bkt_waddr = ent_rbkt;
          bkt_whead = ent_rnext;
          bkt_we    = '{head: 1'b1, tail: 1'b0};
        end
      end
      S_RM_TAIL: begin
        if (nx_q != NIL) begin
          ent_waddr = nx_q[IW-1:0];
          ent_we    = '{nxt: 1'b0, prv: 1'b1, dl: 1'b0, bkt: 1'b0};
          ent_wprev = pp_q;
        end else begin
          bkt_wtail = pp_q;
          bkt_we    = '{head: 1'b0, tail: 1'b1};
        end
        vld_d  = 1'b1;
        st_d   = ST_REMOVED;
        oid_d  = ID_W'(cur_q);
        last_d = 1'b1;
      end
      S_FINISH: begin
        vld_d    = 1'b1;
        st_d     = pend_v_q ? ST_EXPIRED : ST_NONE;
        oid_d    = pend_v_q ? ID_W'(pend_q) : '0;
        last_d   = 1'b1;
        pend_v_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      tick_q   <= '0;
      pos0_q   <= '0;
      posu_q   <= '0;
      lvl_q    <= LVL_FIRST;
      wrap_q   <= 1'b0;
      is_add_q <= 1'b0;
      active_q <= '0;
      pend_v_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      tick_q   <= tick_d;
      pos0_q   <= pos0_d;
      posu_q   <= posu_d;
      lvl_q    <= lvl_d;
      wrap_q   <= wrap_d;
      is_add_q <= is_add_d;
      active_q <= active_d;
      pend_v_q <= pend_v_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    nx_q   <= nx_d;
    tl_q   <= tl_d;
    pp_q   <= pp_d;
    bkt_q  <= bkt_d;
    ival_q <= ival_d;
    pend_q <= pend_d;
    st_q   <= st_d;
    oid_q  <= oid_d;
    last_q <= last_d;
  end

  assign busy_o       = state_q != S_IDLE;
  assign valid_o      = vld_q;
  assign status_o     = st_q;
  assign expired_id_o = oid_q;
  assign last_o       = last_q;

endmodule

// File: sim/hierarchical_timer_wheel_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical timer wheel core testbench
// Drives tick, add, remove and unused-opcode transactions, with random gaps, into the core.
// An independent model of the wheel predicts every result, and each
// strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_core_test;
  import htw_pkg::*;

  localparam int L0_SIZE     = 1 << LEVEL0_BITS_DEF;
  localparam int UP_SIZE     = 1 << UPPER_LEVEL_BITS_DEF;
  localparam int NUM_BUCKETS = L0_SIZE + NUM_UPPER * UP_SIZE;
  localparam int POOL        = POOL_SIZE_DEF;
  localparam logic [6:0] NIL = 7'(POOL);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]         op;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    bit                 drain;
  } cmd_t;

  typedef struct {
    status_e         status;
    logic [ID_W-1:0] id;
    logic            last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         operation_i = OP_TICK;
  logic [ID_W-1:0]    timer_id_i = '0;
  logic [DELAY_W-1:0] delay_ticks_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic [2:0]         status_o;
  logic [ID_W-1:0]    expired_id_o;
  logic               last_o;

  hierarchical_timer_wheel_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .timer_id_i,
    .delay_ticks_i, .valid_o, .status_o, .expired_id_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Wheel model state
  logic [63:0] now_ticks;
  int unsigned spoke [5];
  logic [6:0]  head_q [NUM_BUCKETS];
  logic [6:0]  tail_q [NUM_BUCKETS];
  logic [6:0]  next_q [POOL];
  logic [6:0]  prev_q [POOL];
  logic [63:0] deadline_q [POOL];
  logic [8:0]  home_q [POOL];
  bit          armed [POOL];
  logic [6:0]  fired [$];

  cmd_t    pending_cmds [$];
  result_t wheel_results [$];
  int      total_cmds, accepted_cmds, result_count, expiry_count, wraps_seen;
  int      queued_ticks;
  int      fail_count;
  int      gap_left;
  int unsigned cycle_count;
  cmd_t    cur_cmd;

  function automatic int unsigned level_base(int unsigned k);
    return (k == 0) ? 0 : L0_SIZE + (k - 1) * UP_SIZE;
  endfunction

  function automatic void append_timer(int unsigned b, logic [6:0] e);
    logic [6:0] t;
    t = tail_q[b];
    prev_q[e] = t;
    next_q[e] = NIL;
    if (t < NIL) next_q[t] = e;
    else head_q[b] = e;
    tail_q[b] = e;
    home_q[e] = 9'(b);
  endfunction

  function automatic void unlink_timer(logic [6:0] e);
    int unsigned b;
    logic [6:0] p, n;
    b = home_q[e] % NUM_BUCKETS;
    p = prev_q[e];
    n = next_q[e];
    if (p < NIL) next_q[p] = n;
    else head_q[b] = n;
    if (n < NIL) prev_q[n] = p;
    else tail_q[b] = p;
  endfunction

  function automatic void file_timer(logic [6:0] e, logic [63:0] interval);
    int unsigned k, sh;
    logic [63:0] thr, v;
    if (interval < 64'(L0_SIZE)) begin
      append_timer(32'((interval + 64'(spoke[0])) & 64'(L0_SIZE - 1)), e);
      return;
    end
    for (k = 1; k < 4; k++)
      if (interval < (64'd1 << (LEVEL0_BITS_DEF + k * UPPER_LEVEL_BITS_DEF))) break;
    sh  = LEVEL0_BITS_DEF + (k - 1) * UPPER_LEVEL_BITS_DEF;
    thr = 64'd1 << sh;
    v   = interval - thr + 64'(spoke[k]) * thr;
    append_timer(level_base(k) + 32'((v >> sh) & 64'(UP_SIZE - 1)), e);
  endfunction

  function automatic void fire_timer(logic [6:0] e);
    armed[e] = 1'b0;
    if (fired.size() < POOL) fired.push_back(e);
  endfunction

  function automatic void advance_wheel();
    int unsigned b, k;
    logic [6:0] e, nx;
    b = spoke[0] & (L0_SIZE - 1);
    e = head_q[b];
    fired.delete();
    while (e < NIL) begin
      nx = next_q[e];
      fire_timer(e);
      e = nx;
    end
    head_q[b] = NIL;
    tail_q[b] = NIL;
    spoke[0]++;
    now_ticks++;
    if (spoke[0] < L0_SIZE) return;
    spoke[0] = 0;
    wraps_seen++;
    for (k = 1; k < 5; k++) begin
      b = level_base(k) + (spoke[k] & (UP_SIZE - 1));
      spoke[k]++;
      e = head_q[b];
      head_q[b] = NIL;
      tail_q[b] = NIL;
      while (e < NIL) begin
        nx = next_q[e];
        if (deadline_q[e] <= now_ticks) fire_timer(e);
        else file_timer(e, deadline_q[e] - now_ticks);
        e = nx;
      end
      if (spoke[k] < UP_SIZE) break;
      spoke[k] = 0;
    end
  endfunction

  function automatic void push_result(status_e s, logic [ID_W-1:0] id, logic last);
    result_t r;
    r.status = s;
    r.id     = id;
    r.last   = last;
    wheel_results.push_back(r);
  endfunction

  function automatic void predict_wheel(cmd_t c);
    logic [6:0] e;
    e = {1'b0, c.id};
    if (c.op == OP_TICK) begin
      advance_wheel();
      if (fired.size() == 0) push_result(ST_NONE, '0, 1'b1);
      foreach (fired[i]) begin
        push_result(ST_EXPIRED, fired[i][ID_W-1:0], i == fired.size() - 1);
        expiry_count++;
      end
    end else if (c.op == OP_ADD) begin
      if (armed[e]) push_result(ST_BUSY, c.id, 1'b1);
      else begin
        deadline_q[e] = now_ticks + 64'(c.delay);
        armed[e] = 1'b1;
        file_timer(e, 64'(c.delay));
        push_result(ST_ADDED, c.id, 1'b1);
      end
    end else if (c.op == OP_REMOVE) begin
      if (!armed[e]) push_result(ST_NOT_ACTIVE, c.id, 1'b1);
      else begin
        unlink_timer(e);
        armed[e] = 1'b0;
        push_result(ST_REMOVED, c.id, 1'b1);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(0, 40);
      2:       return $urandom_range(0, 600);
      3:       return $urandom_range(200, 20000);
      4:       return 32'(1) << $urandom_range(8, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] op, logic [ID_W-1:0] id,
                                    logic [DELAY_W-1:0] delay, bit drain);
    cmd_t c;
    c.op    = op;
    c.id    = id;
    c.delay = delay;
    c.drain = drain;
    pending_cmds.push_back(c);
    total_cmds++;
    if (op == OP_TICK) queued_ticks++;
  endfunction

  // Driver: hold start until the transaction is taken, then space the next
  always @(posedge clk_i) begin
    logic nstart;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      nstart = 1'b0;
      if (start_i && !busy_o) begin
        predict_wheel(cur_cmd);
        accepted_cmds++;
      end
      if (start_i && busy_o) nstart = 1'b1;
      else if (gap_left > 0) gap_left--;
      else if (pending_cmds.size() > 0 &&
               (!pending_cmds[0].drain || wheel_results.size() == 0)) begin
        cur_cmd = pending_cmds.pop_front();
        operation_i   <= cur_cmd.op;
        timer_id_i    <= cur_cmd.id;
        delay_ticks_i <= cur_cmd.delay;
        nstart = 1'b1;
        gap_left = pick_gap();
      end
      start_i <= nstart;
    end
  end

  // Monitor: every strobed result must match the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && valid_o) begin
      result_count++;
      if (wheel_results.size() == 0) begin
        $error("unexpected result: status %0d id %0d last %0d",
               status_o, expired_id_o, last_o);
        fail_count++;
      end else begin
        want = wheel_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (expired_id_o !== want.id) begin
          $error("expired_id: expected %0d, actual %0d", want.id, expired_id_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    now_ticks = '0;
    foreach (spoke[i]) spoke[i] = 0;
    foreach (head_q[i]) begin
      head_q[i] = NIL;
      tail_q[i] = NIL;
    end
    foreach (armed[i]) begin
      armed[i] = 1'b0;
      next_q[i] = '0;
      prev_q[i] = '0;
      deadline_q[i] = '0;
      home_q[i] = '0;
    end
    cycle_count = 0;
    gap_left = 0;

    // Directed: empty tick, zero and maximum delays, busy and inactive ids
    queue_cmd(OP_TICK, 6'd0, '0, 0);
    queue_cmd(OP_ADD, 6'd0, '0, 0);
    queue_cmd(OP_TICK, 6'd0, '0, 0);
    queue_cmd(OP_ADD, 6'd1, 32'hFFFF_FFFF, 0);
    queue_cmd(OP_ADD, 6'd1, 32'd5, 0);
    queue_cmd(OP_REMOVE, 6'd2, '0, 0);
    queue_cmd(OP_REMOVE, 6'd1, '0, 0);
    queue_cmd(OP_REMOVE, 6'd1, '0, 0);
    queue_cmd(OP_ADD, 6'd63, 32'd255, 0);
    queue_cmd(OP_ADD, 6'd62, 32'd256, 0);
    queue_cmd(OP_ADD, 6'd5, 32'd300, 0);
    queue_cmd(OP_REMOVE, 6'd62, '0, 0);
    queue_cmd(OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 0);
    queue_cmd(OP_UNUSED, 6'd0, '0, 0);
    for (int i = 10; i < 14; i++) queue_cmd(OP_ADD, 6'(i), 32'd1, 0);
    queue_cmd(OP_TICK, 6'd0, '0, 0);
    queue_cmd(OP_TICK, 6'd0, '0, 1);
    queue_cmd(OP_ADD, 6'd20, 32'd16384, 0);
    queue_cmd(OP_ADD, 6'd21, 32'd1 << 20, 0);
    queue_cmd(OP_ADD, 6'd22, 32'd1 << 26, 0);

    // Random mix of transactions
    for (int i = 0; i < 20; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_cmd(OP_TICK, 6'($urandom), $urandom, i % 10 == 9);
      else if (r < 80) queue_cmd(OP_ADD, 6'($urandom), pick_delay(), 0);
      else if (r < 98) queue_cmd(OP_REMOVE, 6'($urandom), $urandom, 0);
      else queue_cmd(OP_UNUSED, 6'($urandom), $urandom, 0);
    end

    // Tick sweep just long enough to take the wheel through a level-0 wrap
    while (queued_ticks < 260) begin
      r = $urandom_range(0, 99);
      if (r < 4) queue_cmd(OP_ADD, 6'($urandom), pick_delay(), 0);
      else if (r < 5) queue_cmd(OP_REMOVE, 6'($urandom), '0, 0);
      else queue_cmd(OP_TICK, '0, '0, 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cmds == total_cmds && !start_i);
    wait (wheel_results.size() == 0);
    repeat (400) @(posedge clk_i);

    $display("Ran %0d transactions, checked %0d results (%0d expiries, %0d level-0 wraps).",
             accepted_cmds, result_count, expiry_count, wraps_seen);
    if (fail_count == 0 && wheel_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/htw_pkg.sv
hw/rtl/htw_bucket_ram.sv
hw/rtl/htw_entry_ram.sv
hw/rtl/htw_filer.sv
hw/rtl/hierarchical_timer_wheel_core.sv
sim/hierarchical_timer_wheel_core_test.sv
